/* rtl/dcp_pkg.sv */
// Shared types and constants for the discord candidate pruner.
// No dependencies; used by dcp_cell and discord_candidate_pruner.
`default_nettype none
package dcp_pkg;

    localparam int SEQ_LEN        = 1024;
    localparam int MAX_CANDIDATES = 64;

    localparam int ADDR_W = (SEQ_LEN > 1) ? $clog2(SEQ_LEN) : 1;
    localparam int POS_W  = $clog2(SEQ_LEN + 1);
    localparam int SLOT_W = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
    localparam int CNT_W  = 7;
    localparam int DIST_W = 48;
    localparam int SMP_W  = 16;
    localparam int IDX_W  = 16;
    localparam int PROD_W = 32;

    localparam logic [DIST_W-1:0] DIST_MAX     = {DIST_W{1'b1}};
    localparam logic [DIST_W-1:0] RADIUS_RESET = 48'd19796092;

    // configuration register indexes
    localparam logic REG_MODE   = 1'b0;
    localparam logic REG_RADIUS = 1'b1;

    // pass modes
    localparam logic MODE_SELECT = 1'b0;
    localparam logic MODE_REFINE = 1'b1;

    // result kinds
    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample;
        logic [IDX_W-1:0]        seq_index;
        logic                    last_sample;
        logic                    last_sequence;
    } smp_t;

    typedef struct packed {
        logic              kind;
        logic              admitted;
        logic [CNT_W-1:0]  pruned_count;
        logic [CNT_W-1:0]  candidate_count;
        logic              table_full;
        logic [IDX_W-1:0]  cand_index;
        logic [DIST_W-1:0] nearest_sq_dist;
        logic              last;
    } res_t;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic                    smp_go;
        logic signed [SMP_W-1:0] sample;
        logic [ADDR_W-1:0]       addr;
        logic                    wr_en;
        logic [SLOT_W-1:0]       wr_slot;
        logic [SMP_W-1:0]        wr_data;
        logic                    admit;
        logic [SLOT_W-1:0]       admit_slot;
        logic [IDX_W-1:0]        end_idx;
        logic                    mode;
        logic [DIST_W-1:0]       radius;
        logic                    nearest_init;
    } cell_ctl_t;

    // end-of-sequence token passed cell to cell
    typedef struct packed {
        logic              active;
        logic [CNT_W-1:0]  pruned;
        logic [CNT_W-1:0]  count;
        logic              found;
        logic [SLOT_W-1:0] slot;
    } tok_t;

endpackage
`default_nettype wire

/* rtl/dcp_cell.sv */
// One candidate slot: stored sequence memory, distance accumulator, verdict.
// Depends on dcp_pkg.
`default_nettype none
module dcp_cell (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [dcp_pkg::SLOT_W-1:0]  slot_id,
    input  wire dcp_pkg::cell_ctl_t          ctl,
    input  wire dcp_pkg::tok_t               tok_in,
    output dcp_pkg::tok_t                    tok_out,
    output logic                             valid,
    output logic [dcp_pkg::IDX_W-1:0]        seq_idx,
    output logic [dcp_pkg::DIST_W-1:0]       nearest
);

    logic [dcp_pkg::SMP_W-1:0] mem [dcp_pkg::SEQ_LEN];

    logic signed [dcp_pkg::SMP_W-1:0] rd_reg;
    logic signed [dcp_pkg::SMP_W-1:0] smp_reg;
    logic                             go1_reg;
    logic [dcp_pkg::PROD_W-1:0]       prod_reg;
    logic                             go2_reg;
    logic [dcp_pkg::DIST_W-1:0]       partial_reg, partial_next;
    logic [dcp_pkg::DIST_W-1:0]       nearest_reg, nearest_next;
    logic                             valid_reg, valid_next;
    logic [dcp_pkg::IDX_W-1:0]        idx_reg;
    dcp_pkg::tok_t                    tok_reg, tok_next;

    logic signed [dcp_pkg::SMP_W:0]   diff;
    logic signed [2*dcp_pkg::SMP_W+1:0] sq;
    logic [dcp_pkg::DIST_W:0]         sum;
    logic                             eligible;
    logic                             hit;

    assign diff = {smp_reg[dcp_pkg::SMP_W-1], smp_reg} - {rd_reg[dcp_pkg::SMP_W-1], rd_reg};
    assign sq   = diff * diff;
    assign sum  = {1'b0, partial_reg}
                + {{(dcp_pkg::DIST_W + 1 - dcp_pkg::PROD_W){1'b0}}, prod_reg};

    // skip against own index only in refinement
    assign eligible = valid_reg
                    && ((ctl.mode == dcp_pkg::MODE_SELECT) || (idx_reg != ctl.end_idx));
    assign hit = eligible && (partial_reg < ctl.radius);

    always_ff @(posedge clk)
    begin
        if (ctl.smp_go)
        begin
            rd_reg  <= $signed(mem[ctl.addr]);
            smp_reg <= ctl.sample;
        end
        if (ctl.wr_en && (ctl.wr_slot == slot_id))
        begin
            mem[ctl.addr] <= ctl.wr_data;
        end
        if (go1_reg)
        begin
            prod_reg <= sq[dcp_pkg::PROD_W-1:0];
        end
        if (ctl.admit && (ctl.admit_slot == slot_id))
        begin
            idx_reg <= ctl.end_idx;
        end
    end

    always_comb
    begin
        partial_next = partial_reg;
        nearest_next = nearest_reg;
        valid_next   = valid_reg;
        tok_next     = tok_in;
        if (go2_reg)
        begin
            partial_next = sum[dcp_pkg::DIST_W] ? dcp_pkg::DIST_MAX
                                                : sum[dcp_pkg::DIST_W-1:0];
        end
        if (tok_in.active)
        begin
            partial_next = '0;
            if (hit)
            begin
                valid_next      = 1'b0;
                tok_next.pruned = tok_in.pruned + 1'b1;
            end
            else
            begin
                if (eligible && (ctl.mode == dcp_pkg::MODE_REFINE)
                    && (partial_reg < nearest_reg))
                begin
                    nearest_next = partial_reg;
                end
                if (valid_reg)
                begin
                    tok_next.count = tok_in.count + 1'b1;
                end
            end
            if (!tok_in.found && !(valid_reg && !hit))
            begin
                tok_next.found = 1'b1;
                tok_next.slot  = slot_id;
            end
        end
        if (ctl.admit && (ctl.admit_slot == slot_id))
        begin
            valid_next = 1'b1;
        end
        if (ctl.nearest_init)
        begin
            nearest_next = dcp_pkg::DIST_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            go1_reg     <= 1'b0;
            go2_reg     <= 1'b0;
            partial_reg <= '0;
            nearest_reg <= dcp_pkg::DIST_MAX;
            valid_reg   <= 1'b0;
            tok_reg     <= '0;
        end
        else
        begin
            go1_reg     <= ctl.smp_go;
            go2_reg     <= go1_reg;
            partial_reg <= partial_next;
            nearest_reg <= nearest_next;
            valid_reg   <= valid_next;
            tok_reg     <= tok_next;
        end
    end

    assign tok_out = tok_reg;
    assign valid   = valid_reg;
    assign seq_idx = idx_reg;
    assign nearest = nearest_reg;

endmodule
`default_nettype wire

/* rtl/discord_candidate_pruner.sv */
// Discord candidate pruner: sequencer, incoming buffer and the row of cells.
// Throughput: one item per cycle within a sequence; items without last_sample give no result.
// Last item of a sequence to first result: drain, the token through the cell row, then emit;
// an admitted sequence adds a copy sweep of SEQ_LEN samples into its slot before emit.
// Input stalls until the last result is registered, longer for each empty slot passed over
// in a final report and while res_stall holds.
`default_nettype none
module discord_candidate_pruner (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           smp_valid,
    output logic                                smp_stall,
    input  wire dcp_pkg::smp_t                  smp,
    output logic                                res_valid,
    input  wire logic                           res_stall,
    output dcp_pkg::res_t                       res,
    input  wire logic                           cfg_we,
    input  wire logic                           cfg_index,
    input  wire logic [dcp_pkg::DIST_W-1:0]     cfg_data
);

    // Reset: asynchronous, active low; empties the table, mode = selection, default radius.

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DRAIN = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_COPY  = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // incoming sequence buffer, read only by the copy sweep
    logic [dcp_pkg::SMP_W-1:0] buf_mem [dcp_pkg::SEQ_LEN];
    logic [dcp_pkg::SMP_W-1:0] buf_rd_reg;

    logic                        mode_reg;
    logic [dcp_pkg::DIST_W-1:0]  radius_reg;
    logic [dcp_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [dcp_pkg::IDX_W-1:0]   end_idx_reg;
    logic                        end_lq_reg;
    logic [1:0]                  drain_reg, drain_next;
    logic                        scan_first_reg, scan_first_next;
    logic [dcp_pkg::CNT_W-1:0]   pruned_reg, pruned_next;
    logic [dcp_pkg::CNT_W-1:0]   count_reg, count_next;
    logic                        adm_reg, adm_next;
    logic                        full_reg, full_next;
    logic [dcp_pkg::SLOT_W-1:0]  slot_reg, slot_next;
    logic [dcp_pkg::POS_W-1:0]   cp_cnt_reg, cp_cnt_next;
    logic                        cp_we_reg;
    logic [dcp_pkg::ADDR_W-1:0]  cp_addr_reg;
    logic [dcp_pkg::SLOT_W:0]    scan_j_reg, scan_j_next;
    logic [dcp_pkg::CNT_W-1:0]   rep_k_reg, rep_k_next;
    logic                        res_valid_reg, res_valid_next;
    dcp_pkg::res_t               res_reg, res_next;

    logic                        accept;
    logic                        in_range;
    logic                        res_free;
    logic                        cp_rd;
    logic                        admit;
    dcp_pkg::cell_ctl_t          ctl;
    dcp_pkg::tok_t               tok [dcp_pkg::MAX_CANDIDATES + 1];
    logic                        cell_valid [dcp_pkg::MAX_CANDIDATES];
    logic [dcp_pkg::IDX_W-1:0]   cell_idx   [dcp_pkg::MAX_CANDIDATES];
    logic [dcp_pkg::DIST_W-1:0]  cell_near  [dcp_pkg::MAX_CANDIDATES];
    dcp_pkg::tok_t               tok_last;
    logic [dcp_pkg::SLOT_W-1:0]  j_slot;

    assign smp_stall = (state_reg != ST_IDLE);
    assign accept    = smp_valid && !smp_stall;
    assign in_range  = (pos_reg < dcp_pkg::SEQ_LEN[dcp_pkg::POS_W-1:0]);
    assign res_free  = !res_valid_reg || !res_stall;
    assign cp_rd     = (state_reg == ST_COPY)
                     && (cp_cnt_reg < dcp_pkg::SEQ_LEN[dcp_pkg::POS_W-1:0]);
    assign tok_last  = tok[dcp_pkg::MAX_CANDIDATES];
    assign j_slot    = scan_j_reg[dcp_pkg::SLOT_W-1:0];

    // in selection mode, admit the sequence when the token returns with nothing pruned and a free slot
    assign admit = (state_reg == ST_SCAN) && tok_last.active
                 && (mode_reg == dcp_pkg::MODE_SELECT)
                 && (tok_last.pruned == '0) && tok_last.found;

    // broadcast to the cell row
    always_comb
    begin
        ctl              = '0;
        ctl.smp_go       = accept && in_range;
        ctl.sample       = smp.sample;
        ctl.addr         = (state_reg == ST_IDLE) ? pos_reg[dcp_pkg::ADDR_W-1:0]
                                                  : cp_addr_reg;
        ctl.wr_en        = cp_we_reg;
        ctl.wr_slot      = slot_reg;
        ctl.wr_data      = buf_rd_reg;
        ctl.admit        = admit;
        ctl.admit_slot   = tok_last.slot;
        ctl.end_idx      = end_idx_reg;
        ctl.mode         = mode_reg;
        ctl.radius       = radius_reg;
        ctl.nearest_init = cfg_we && (cfg_index == dcp_pkg::REG_MODE) && cfg_data[0];
    end

    always_comb
    begin
        tok[0]        = '0;
        tok[0].active = (state_reg == ST_SCAN) && scan_first_reg;
    end

    for (genvar c = 0; c < dcp_pkg::MAX_CANDIDATES; c++)
    begin : g_cell
        dcp_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .slot_id (dcp_pkg::SLOT_W'(c)),
            .ctl     (ctl),
            .tok_in  (tok[c]),
            .tok_out (tok[c+1]),
            .valid   (cell_valid[c]),
            .seq_idx (cell_idx[c]),
            .nearest (cell_near[c])
        );
    end

    // buffer write on accept, registered read during the copy sweep
    always_ff @(posedge clk)
    begin
        if (accept && in_range)
        begin
            buf_mem[pos_reg[dcp_pkg::ADDR_W-1:0]] <= smp.sample;
        end
        if (cp_rd)
        begin
            buf_rd_reg  <= buf_mem[cp_cnt_reg[dcp_pkg::ADDR_W-1:0]];
            cp_addr_reg <= cp_cnt_reg[dcp_pkg::ADDR_W-1:0];
        end
        if (accept && smp.last_sample)
        begin
            end_idx_reg <= smp.seq_index;
            end_lq_reg  <= smp.last_sequence;
        end
        res_reg <= res_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        drain_next      = drain_reg;
        scan_first_next = 1'b0;
        pruned_next     = pruned_reg;
        count_next      = count_reg;
        adm_next        = adm_reg;
        full_next       = full_reg;
        slot_next       = slot_reg;
        cp_cnt_next     = cp_cnt_reg;
        scan_j_next     = scan_j_reg;
        rep_k_next      = rep_k_reg;
        res_valid_next  = res_valid_reg && res_stall;
        res_next        = res_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_range)
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                    if (smp.last_sample)
                    begin
                        pos_next   = '0;
                        drain_next = 2'd2;
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                // let the last product reach the accumulators
                drain_next = drain_reg - 1'b1;
                if (drain_reg == 2'd1)
                begin
                    scan_first_next = 1'b1;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (tok_last.active)
                begin
                    pruned_next = tok_last.pruned;
                    count_next  = tok_last.count + {{(dcp_pkg::CNT_W-1){1'b0}}, admit};
                    adm_next    = admit;
                    full_next   = (mode_reg == dcp_pkg::MODE_SELECT)
                                && (tok_last.pruned == '0) && !tok_last.found;
                    slot_next   = tok_last.slot;
                    cp_cnt_next = '0;
                    scan_j_next = '0;
                    rep_k_next  = '0;
                    state_next  = admit ? ST_COPY : ST_EMIT;
                end
            end
            ST_COPY:
            begin
                if (cp_rd)
                begin
                    cp_cnt_next = cp_cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if ((mode_reg == dcp_pkg::MODE_SELECT) || !end_lq_reg || (count_reg == '0))
                begin
                    if (res_free)
                    begin
                        res_valid_next           = 1'b1;
                        res_next                 = '0;
                        res_next.kind            = dcp_pkg::KIND_VERDICT;
                        res_next.admitted        = adm_reg;
                        res_next.pruned_count    = pruned_reg;
                        res_next.candidate_count = count_reg;
                        res_next.table_full      = full_reg;
                        res_next.last            = end_lq_reg;
                        state_next               = ST_IDLE;
                    end
                end
                else if (!cell_valid[j_slot])
                begin
                    scan_j_next = scan_j_reg + 1'b1;
                end
                else if (res_free)
                begin
                    // one report per survivor, in slot order
                    res_valid_next           = 1'b1;
                    res_next                 = '0;
                    res_next.kind            = dcp_pkg::KIND_REPORT;
                    res_next.pruned_count    = pruned_reg;
                    res_next.candidate_count = count_reg;
                    res_next.cand_index      = cell_idx[j_slot];
                    res_next.nearest_sq_dist = cell_near[j_slot];
                    res_next.last            = ((rep_k_reg + 1'b1) == count_reg);
                    rep_k_next               = rep_k_reg + 1'b1;
                    scan_j_next              = scan_j_reg + 1'b1;
                    if ((rep_k_reg + 1'b1) == count_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mode_reg       <= dcp_pkg::MODE_SELECT;
            radius_reg     <= dcp_pkg::RADIUS_RESET;
            pos_reg        <= '0;
            drain_reg      <= '0;
            scan_first_reg <= 1'b0;
            pruned_reg     <= '0;
            count_reg      <= '0;
            adm_reg        <= 1'b0;
            full_reg       <= 1'b0;
            slot_reg       <= '0;
            cp_cnt_reg     <= '0;
            cp_we_reg      <= 1'b0;
            scan_j_reg     <= '0;
            rep_k_reg      <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            drain_reg      <= drain_next;
            scan_first_reg <= scan_first_next;
            pruned_reg     <= pruned_next;
            count_reg      <= count_next;
            adm_reg        <= adm_next;
            full_reg       <= full_next;
            slot_reg       <= slot_next;
            cp_cnt_reg     <= cp_cnt_next;
            cp_we_reg      <= cp_rd;
            scan_j_reg     <= scan_j_next;
            rep_k_reg      <= rep_k_next;
            res_valid_reg  <= res_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    dcp_pkg::REG_MODE:   mode_reg   <= cfg_data[0];
                    dcp_pkg::REG_RADIUS: radius_reg <= cfg_data;
                    default:             mode_reg   <= mode_reg;
                endcase
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
`default_nettype wire
